@@ hw/rtl/sqld_pkg.sv @@
// Shared package for the sparse query LUT distance block.
// Holds command codes, default sizes and controller command types.
`timescale 1ns / 1ps
package sqld_pkg;
    localparam int COMPACT_ID_BITS_DEF = 14;
    localparam int CODE_COUNT_DEF = 256;
    localparam int CODEBOOK_INDEX_BITS_DEF = 6;

    localparam logic [2:0] CMD_CB_WRITE = 3'd0;
    localparam logic [2:0] CMD_TERM_BOOK = 3'd1;
    localparam logic [2:0] CMD_QWEIGHT = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_HEADER = 3'd4;
    localparam logic [2:0] CMD_ELEMENT = 3'd5;

    localparam logic signed [48:0] ONE_Q16 = 49'sd65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the input beat
        logic cb_write;
        logic term_write;
        logic qw_write;
        logic clear_step;
        logic header;
        logic lookup;     // stage 1: read term tables
        logic cb_read;    // stage 2: read codebook
        logic mul;        // stage 3: product
        logic accum;      // stage 4: add to sums
        logic fin_mul;    // stage 5: low partial products
        logic fin_hi;     // stage 6: high partial products, full products
        logic fin_rnd;    // stage 7: round final products
        logic fin_out;    // stage 8: output value
    } sqld_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic emit_elem;
        logic emit_hdr;
        logic [2:0] command;
    } sqld_stat_t;
endpackage

@@ hw/rtl/sqld_datapath.sv @@
// Datapath: tables, accumulators and final distance arithmetic.
// Depends on sqld_pkg.
`timescale 1ns / 1ps
module sqld_datapath #(
    parameter int COMPACT_ID_BITS = sqld_pkg::COMPACT_ID_BITS_DEF,
    parameter int CODE_COUNT = sqld_pkg::CODE_COUNT_DEF,
    parameter int CODEBOOK_INDEX_BITS = sqld_pkg::CODEBOOK_INDEX_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  sqld_pkg::sqld_cmd_t cmd,
    output sqld_pkg::sqld_stat_t stat,
    input  logic [2:0] command,
    input  logic [5:0] book_sel,
    input  logic [7:0] code,
    input  logic [13:0] term_id,
    input  logic signed [31:0] value,
    input  logic signed [31:0] vector_mean,
    input  logic signed [31:0] vector_alpha,
    input  logic empty_vector,
    input  logic last,
    output logic signed [31:0] distance
);
    localparam int IDS = 1 << COMPACT_ID_BITS;
    localparam int CODE_BITS = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;
    localparam int CB_BITS = CODEBOOK_INDEX_BITS + CODE_BITS;
    localparam int CB_DEPTH = 1 << CB_BITS;
    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    logic signed [31:0] cb_mem [CB_DEPTH];
    logic [CODEBOOK_INDEX_BITS-1:0] tb_mem [IDS];
    logic signed [31:0] qw_mem [IDS];
    logic qv_mem [IDS];

    logic [2:0] cmd_reg;
    logic [CODEBOOK_INDEX_BITS-1:0] book_reg;
    logic [7:0] code_reg;
    logic [COMPACT_ID_BITS-1:0] id_reg;
    logic signed [31:0] val_reg, mean_in_reg, alpha_in_reg;
    logic empty_reg, last_reg;
    logic [COMPACT_ID_BITS-1:0] clr_reg;

    logic signed [31:0] mean_reg, alpha_reg, w_reg, cv_reg;
    logic signed [47:0] wsum_reg, psum_reg, prod_reg;
    logic [CODEBOOK_INDEX_BITS-1:0] tb_rd_reg;
    logic qv_rd_reg;
    logic signed [56:0] t1_lo_reg, t2_lo_reg;
    logic signed [79:0] p1_reg, p2_reg;
    logic signed [63:0] t1_reg, t2_reg;
    logic signed [31:0] dist_reg;

    logic [CODE_BITS-1:0] code_sat;
    assign code_sat = ({24'd0, code_reg} >= 32'(CODE_COUNT)) ?
        CODE_BITS'(CODE_COUNT - 1) : CODE_BITS'(code_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= command;
            book_reg <= CODEBOOK_INDEX_BITS'(book_sel);
            code_reg <= code;
            id_reg <= COMPACT_ID_BITS'(term_id);
            val_reg <= value;
            mean_in_reg <= vector_mean;
            alpha_in_reg <= vector_alpha;
            empty_reg <= empty_vector;
            last_reg <= last;
        end
        if (cmd.cb_write && ({24'd0, code_reg} < 32'(CODE_COUNT)))
            cb_mem[{book_reg, CODE_BITS'(code_reg)}] <= val_reg;
        if (cmd.term_write)
            tb_mem[id_reg] <= book_reg;
        if (cmd.qw_write)
            qw_mem[id_reg] <= val_reg;
        if (cmd.lookup)
        begin
            tb_rd_reg <= tb_mem[id_reg];
            w_reg <= qw_mem[id_reg];
        end
        if (cmd.cb_read)
            cv_reg <= cb_mem[CB_BITS'({tb_rd_reg, code_sat})];
    end

    // Query valid bits: single port, cleared by a sweep after reset and on a clear.
    always_ff @(posedge clk)
    begin
        if (cmd.qw_write)
            qv_mem[id_reg] <= 1'b1;
        else if (cmd.clear_step)
            qv_mem[clr_reg] <= 1'b0;
        if (cmd.lookup)
            qv_rd_reg <= qv_mem[id_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_step)
            clr_reg <= clr_reg + 1'b1;
    end

    // Rounds an exact Q32.32 product to Q16.16, ties away from zero.
    function automatic logic signed [63:0] round_q16(input logic signed [79:0] p);
        logic [79:0] m;
        logic [63:0] r;
        m = p[79] ? 80'(-p) : 80'(p);
        r = m[79:16] + {63'd0, m[15]};
        return p[79] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                    input logic signed [47:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s > 49'(ACC_MAX)) return ACC_MAX;
        if (s < 49'(ACC_MIN)) return ACC_MIN;
        return s[47:0];
    endfunction

    // The 48-bit sums are split into a signed high and an unsigned low half so
    // that each final product is built from two narrow multiplies.
    logic signed [63:0] elem_p;
    logic signed [24:0] wsum_lo, psum_lo;
    logic signed [23:0] wsum_hi, psum_hi;
    logic signed [55:0] t1_hi, t2_hi;
    assign elem_p = w_reg * cv_reg;
    assign wsum_lo = $signed({1'b0, wsum_reg[23:0]});
    assign psum_lo = $signed({1'b0, psum_reg[23:0]});
    assign wsum_hi = $signed(wsum_reg[47:24]);
    assign psum_hi = $signed(psum_reg[47:24]);
    assign t1_hi = mean_reg * wsum_hi;
    assign t2_hi = alpha_reg * psum_hi;

    logic signed [64:0] fsum;
    logic signed [64:0] fres;
    assign fsum = 65'(t1_reg) + 65'(t2_reg);
    assign fres = 65'(sqld_pkg::ONE_Q16) - fsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            alpha_reg <= '0;
            wsum_reg <= '0;
            psum_reg <= '0;
        end
        else
        begin
            if (cmd.header)
            begin
                mean_reg <= mean_in_reg;
                alpha_reg <= alpha_in_reg;
                wsum_reg <= '0;
                psum_reg <= '0;
            end
            else if (cmd.accum && qv_rd_reg)
            begin
                wsum_reg <= sat_add(wsum_reg, 48'(w_reg));
                psum_reg <= sat_add(psum_reg, prod_reg);
            end
            else if (cmd.fin_out)
            begin
                wsum_reg <= '0;
                psum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= 48'(round_q16(80'(elem_p)));
        if (cmd.fin_mul)
        begin
            t1_lo_reg <= mean_reg * wsum_lo;
            t2_lo_reg <= alpha_reg * psum_lo;
        end
        if (cmd.fin_hi)
        begin
            p1_reg <= $signed({t1_hi, 24'd0}) + 80'(t1_lo_reg);
            p2_reg <= $signed({t2_hi, 24'd0}) + 80'(t2_lo_reg);
        end
        if (cmd.fin_rnd)
        begin
            t1_reg <= round_q16(p1_reg);
            t2_reg <= round_q16(p2_reg);
        end
        if (cmd.fin_out)
        begin
            if (fsum > 65'sd1099511627776)
                dist_reg <= 32'sh8000_0000;
            else if (fsum < -65'sd1099511627776)
                dist_reg <= 32'sh7FFF_FFFF;
            else if (fres > 65'sd2147483647)
                dist_reg <= 32'sh7FFF_FFFF;
            else if (fres < -65'sd2147483648)
                dist_reg <= 32'sh8000_0000;
            else
                dist_reg <= fres[31:0];
        end
    end

    assign distance = dist_reg;
    assign stat.clear_done = (clr_reg == {COMPACT_ID_BITS{1'b1}});
    assign stat.emit_elem = last_reg;
    assign stat.emit_hdr = empty_reg;
    assign stat.command = cmd_reg;
endmodule

@@ hw/rtl/sqld_ctrl.sv @@
// Controller state machine sequencing each accepted beat through the datapath.
// Depends on sqld_pkg.
`timescale 1ns / 1ps
module sqld_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sqld_pkg::sqld_stat_t stat,
    output sqld_pkg::sqld_cmd_t cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC = 4'd1;
    localparam logic [3:0] S_CLR = 4'd2;
    localparam logic [3:0] S_LK = 4'd3;
    localparam logic [3:0] S_CB = 4'd4;
    localparam logic [3:0] S_MUL = 4'd5;
    localparam logic [3:0] S_ACC = 4'd6;
    localparam logic [3:0] S_FM = 4'd7;
    localparam logic [3:0] S_FO = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;
    localparam logic [3:0] S_FH = 4'd10;
    localparam logic [3:0] S_FR = 4'd11;

    logic [3:0] state_reg, state_next;
    logic ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg;
        cmd = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DEC;
                end
            S_DEC:
                case (stat.command)
                    sqld_pkg::CMD_CB_WRITE: begin cmd.cb_write = 1'b1; state_next = S_IDLE; end
                    sqld_pkg::CMD_TERM_BOOK: begin cmd.term_write = 1'b1; state_next = S_IDLE; end
                    sqld_pkg::CMD_QWEIGHT: begin cmd.qw_write = 1'b1; state_next = S_IDLE; end
                    sqld_pkg::CMD_CLEAR: state_next = S_CLR;
                    sqld_pkg::CMD_HEADER:
                    begin
                        cmd.header = 1'b1;
                        state_next = stat.emit_hdr ? S_FM : S_IDLE;
                    end
                    sqld_pkg::CMD_ELEMENT: state_next = S_LK;
                    default: state_next = S_IDLE;
                endcase
            S_CLR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_LK: begin cmd.lookup = 1'b1; state_next = S_CB; end
            S_CB: begin cmd.cb_read = 1'b1; state_next = S_MUL; end
            S_MUL: begin cmd.mul = 1'b1; state_next = S_ACC; end
            S_ACC:
            begin
                cmd.accum = 1'b1;
                state_next = stat.emit_elem ? S_FM : S_IDLE;
            end
            S_FM: begin cmd.fin_mul = 1'b1; state_next = S_FH; end
            S_FH: begin cmd.fin_hi = 1'b1; state_next = S_FR; end
            S_FR: begin cmd.fin_rnd = 1'b1; state_next = S_FO; end
            S_FO:
                if (!ov_next)
                begin
                    cmd.fin_out = 1'b1;
                    state_next = S_OUT;
                end
            S_OUT: begin ov_next = 1'b1; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase
    end

    // Reset enters the clear sweep so that every query valid bit starts at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg)
        else $error("result beat dropped while stalled");
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> state_reg == S_IDLE)
        else $error("beat taken while busy");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_out |-> !ov_reg || !out_stall)
        else $error("output overwritten");
endmodule

@@ hw/rtl/sparse_query_lut_distance.sv @@
// Top level of the sparse query LUT distance block.
// Depends on sqld_pkg, sqld_ctrl and sqld_datapath.
// One beat is worked on at a time. A table write or a non-empty header is carried out in the
// decode step; an element is looked up, read from its codebook, multiplied and added to the sums.
// After the last element, or after an empty header, the final products are formed and rounded
// and the result is output; the output step waits while an earlier result beat is still stalled.
// A clear sweeps the valid bits one id per cycle. Reset clears the controller, held factors
// and sums, then runs the same sweep with the input stalled; tables are undefined until written.
`timescale 1ns / 1ps
module sparse_query_lut_distance #(
    parameter int COMPACT_ID_BITS = sqld_pkg::COMPACT_ID_BITS_DEF,
    parameter int CODE_COUNT = sqld_pkg::CODE_COUNT_DEF,
    parameter int CODEBOOK_INDEX_BITS = sqld_pkg::CODEBOOK_INDEX_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [2:0] command,
    input  logic [5:0] book_sel,
    input  logic [7:0] code,
    input  logic [13:0] term_id,
    input  logic signed [31:0] value,
    input  logic signed [31:0] vector_mean,
    input  logic signed [31:0] vector_alpha,
    input  logic empty_vector,
    input  logic last,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [31:0] distance
);
    // The controller and datapath talk only through these two structs.
    sqld_pkg::sqld_cmd_t cmd;
    sqld_pkg::sqld_stat_t stat;

    sqld_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .stat(stat), .cmd(cmd)
    );

    sqld_datapath #(
        .COMPACT_ID_BITS(COMPACT_ID_BITS),
        .CODE_COUNT(CODE_COUNT),
        .CODEBOOK_INDEX_BITS(CODEBOOK_INDEX_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .command(command), .book_sel(book_sel), .code(code),
        .term_id(term_id), .value(value), .vector_mean(vector_mean),
        .vector_alpha(vector_alpha), .empty_vector(empty_vector), .last(last),
        .distance(distance)
    );
endmodule
